FILE: rtl/core/blfa_pkg.sv
`timescale 1ns / 1ps

package blfa_pkg;

    localparam int ITEM_W   = 12;
    localparam int FUNC_W   = 3;
    localparam int ITEM_MAX = 4095;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FILL  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_RMW,
        ST_FILL,
        ST_DONE
    } t_state;

    // summary flag update
    typedef struct packed {
        logic clr_all;
        logic upd;
        logic full;
    } t_sum_cmd;

endpackage

FILE: rtl/core/blfa_if.sv
`timescale 1ns / 1ps

interface blfa_in_if;
    import blfa_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ITEM_W-1:0] item_index;

    modport source (output valid, output func, output item_index, input ready);
    modport sink   (input valid, input func, input item_index, output ready);
endinterface

interface blfa_out_if;
    import blfa_pkg::*;

    logic              valid;
    logic              ready;
    logic [ITEM_W-1:0] result_index;
    logic              hit;
    logic              full_res;

    modport source (output valid, output result_index, output hit, output full_res, input ready);
    modport sink   (input valid, input result_index, input hit, input full_res, output ready);
endinterface

FILE: rtl/core/blfa_ram.sv
`timescale 1ns / 1ps

module blfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/blfa_summary.sv
`timescale 1ns / 1ps

module blfa_summary #(
    parameter int MAP_WORDS = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  blfa_pkg::t_sum_cmd                            i_cmd,
    input  logic [$clog2(MAP_WORDS > 1 ? MAP_WORDS : 2)-1:0] i_upd_addr,
    input  logic [$clog2(MAP_WORDS > 1 ? MAP_WORDS : 2)-1:0] i_look_addr,
    output logic                                          o_look_valid,
    output logic [$clog2(MAP_WORDS > 1 ? MAP_WORDS : 2)-1:0] o_pick
);
    import blfa_pkg::*;

    localparam int AW = $clog2(MAP_WORDS > 1 ? MAP_WORDS : 2);

    // per word: written since last clear, and all bits set
    logic [MAP_WORDS-1:0] r_valid;
    logic [MAP_WORDS-1:0] r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            r_valid <= '0;
            r_full  <= '0;
        end else if (i_cmd.upd) begin
            r_valid[i_upd_addr] <= 1'b1;
            r_full[i_upd_addr]  <= i_cmd.full;
        end
    end

    always_comb begin
        o_look_valid = 1'b0;
        if (int'(i_look_addr) < MAP_WORDS) begin
            o_look_valid = r_valid[i_look_addr];
        end
    end

    // lowest word with a clear bit
    always_comb begin
        o_pick = '0;
        for (int w = MAP_WORDS - 1; w >= 0; w--) begin
            if (!r_full[w[AW-1:0]]) begin
                o_pick = AW'(w);
            end
        end
    end

endmodule

FILE: rtl/core/bitmap_lowest_free_allocator.sv
`timescale 1ns / 1ps
// Lowest-free bitmap allocator, one command at a time.
// Allocate goes straight to read-modify-write; clear and unknown commands go to done;
// mark and test first split the index into word and bit; fill writes every map word.
// The next command is taken while a result waits.
// Map words read and written through one RAM port pair with a registered read.
// Reset (synchronous, active low): map reads as empty at once, item_count 4095.
module bitmap_lowest_free_allocator #(
    parameter int WORD_BITS = 64,
    parameter int MAP_WORDS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    blfa_in_if.sink                       i_cmd,
    blfa_out_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [blfa_pkg::ITEM_W-1:0]   i_cfg_wdata
);
    import blfa_pkg::*;

    localparam int AW       = $clog2(MAP_WORDS > 1 ? MAP_WORDS : 2);
    localparam int BW       = $clog2(WORD_BITS);
    localparam int MAP_BITS = WORD_BITS * MAP_WORDS;
    localparam int LIM      = (MAP_BITS - 1 < ITEM_MAX) ? MAP_BITS - 1 : ITEM_MAX;
    localparam int DIV_SH   = 16;
    localparam int DIV_M    = (1 << DIV_SH) / WORD_BITS;
    localparam int DM_W     = $clog2(DIV_M + 1);
    localparam int PW       = ITEM_W + DM_W;

    function automatic logic [WORD_BITS-1:0] valid_mask(input logic [AW-1:0] w,
                                                       input logic [ITEM_W-1:0] eff);
        int lo;
        int top;
        logic [WORD_BITS-1:0] m;
        lo = int'(w) * WORD_BITS;
        m  = '0;
        if (eff != '0 && lo <= int'(eff)) begin
            top = int'(eff) - lo;
            if (top >= WORD_BITS - 1) begin
                m = '1;
            end else begin
                m = ({{(WORD_BITS-1){1'b0}}, 1'b1} << (top + 1)) - 1'b1;
            end
            if (w == '0) begin
                m[0] = 1'b0;
            end
        end
        return m;
    endfunction

    // bit 0 of word 0 is the null item and never stored
    function automatic logic word_full(input logic [AW-1:0] w,
                                       input logic [WORD_BITS-1:0] d);
        logic [WORD_BITS-1:0] t;
        t = d;
        if (w == '0) begin
            t[0] = 1'b1;
        end
        return &t;
    endfunction

    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [ITEM_W-1:0]   r_idx, n_idx;
    logic [ITEM_W-1:0]   r_q0, n_q0;
    logic [AW-1:0]       r_addr, n_addr;
    logic [BW-1:0]       r_bit, n_bit;
    logic [AW-1:0]       r_sweep, n_sweep;
    logic                r_out_valid, n_out_valid;
    logic [ITEM_W-1:0]   r_res, n_res;
    logic                r_hit, n_hit;
    logic                r_full, n_full;
    logic [ITEM_W-1:0]   r_item_count;

    logic [ITEM_W-1:0]    eff;
    logic [PW-1:0]        prod;
    logic [ITEM_W-1:0]    q0wb, rem0, q_fix, rem_fix;
    logic                 step;
    logic                 in_rng;
    logic                 proceed;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
    logic [WORD_BITS-1:0] cur_word, free_bits, word_mask, fill_word;
    logic [BW-1:0]        ff_bit;

    t_sum_cmd             sum_cmd;
    logic [AW-1:0]        sum_addr;
    logic                 look_valid;
    logic [AW-1:0]        pick;

    blfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    blfa_summary #(
        .MAP_WORDS (MAP_WORDS)
    ) u_summary (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (sum_cmd),
        .i_upd_addr   (sum_addr),
        .i_look_addr  (r_addr),
        .o_look_valid (look_valid),
        .o_pick       (pick)
    );

    assign eff = (r_item_count > ITEM_W'(LIM)) ? ITEM_W'(LIM) : r_item_count;

    // word = index / WORD_BITS by reciprocal, one correction step
    assign prod    = PW'(i_cmd.item_index) * PW'(DIV_M);
    assign q0wb    = ITEM_W'(r_q0 * ITEM_W'(WORD_BITS));
    assign rem0    = r_idx - q0wb;
    assign step    = rem0 >= ITEM_W'(WORD_BITS);
    assign q_fix   = step ? r_q0 + 1'b1 : r_q0;
    assign rem_fix = step ? rem0 - ITEM_W'(WORD_BITS) : rem0;

    assign in_rng    = (r_idx != '0) && (r_idx <= eff);
    assign cur_word  = look_valid ? ram_rdata : '0;
    assign word_mask = valid_mask(r_addr, eff);
    assign free_bits = ~cur_word & word_mask;
    assign fill_word = valid_mask(r_sweep, eff);

    always_comb begin
        ff_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b[BW-1:0]]) begin
                ff_bit = BW'(b);
            end
        end
    end

    assign proceed = !r_out_valid || o_res.ready;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_idx       = r_idx;
        n_q0        = r_q0;
        n_addr      = r_addr;
        n_bit       = r_bit;
        n_sweep     = r_sweep;
        n_res       = r_res;
        n_hit       = r_hit;
        n_full      = r_full;
        n_out_valid = r_out_valid && !o_res.ready;
        i_cmd.ready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = cur_word;
        ram_raddr   = r_addr;
        sum_cmd     = '0;
        sum_addr    = r_addr;

        case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
                ram_raddr   = pick;
                if (i_cmd.valid) begin
                    n_func  = i_cmd.func;
                    n_idx   = i_cmd.item_index;
                    n_q0    = ITEM_W'(prod >> DIV_SH);
                    n_addr  = pick;
                    n_sweep = '0;
                    case (i_cmd.func)
                        FUNC_ALLOC: n_state = ST_RMW;
                        FUNC_MARK,
                        FUNC_TEST:  n_state = ST_ADDR;
                        FUNC_FILL:  n_state = ST_FILL;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADDR: begin
                ram_raddr = q_fix[AW-1:0];
                n_addr    = q_fix[AW-1:0];
                n_bit     = rem_fix[BW-1:0];
                n_state   = ST_RMW;
            end
            ST_RMW: begin
                if (proceed) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    case (r_func)
                        FUNC_ALLOC: begin
                            ram_wdata          = cur_word;
                            ram_wdata[ff_bit]  = 1'b1;
                            ram_we             = |free_bits;
                            n_res  = (|free_bits)
                                   ? ITEM_W'(int'(r_addr) * WORD_BITS + int'(ff_bit)) : '0;
                            n_hit  = |free_bits;
                            n_full = ~|free_bits;
                        end
                        FUNC_MARK: begin
                            ram_wdata        = cur_word;
                            ram_wdata[r_bit] = 1'b1;
                            ram_we           = in_rng;
                            n_res  = r_idx;
                            n_hit  = 1'b0;
                            n_full = 1'b0;
                        end
                        default: begin
                            n_res  = r_idx;
                            n_hit  = in_rng && cur_word[r_bit];
                            n_full = 1'b0;
                        end
                    endcase
                    sum_cmd.upd  = ram_we;
                    sum_cmd.full = word_full(r_addr, ram_wdata);
                end
            end
            ST_FILL: begin
                ram_we       = 1'b1;
                ram_waddr    = r_sweep;
                ram_wdata    = fill_word;
                sum_addr     = r_sweep;
                sum_cmd.upd  = 1'b1;
                sum_cmd.full = word_full(r_sweep, fill_word);
                n_sweep      = r_sweep + 1'b1;
                if (r_sweep == AW'(MAP_WORDS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (proceed) begin
                    n_out_valid     = 1'b1;
                    n_res           = '0;
                    n_hit           = 1'b0;
                    n_full          = 1'b0;
                    sum_cmd.clr_all = (r_func == FUNC_CLEAR);
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_item_count <= ITEM_W'(ITEM_MAX);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_item_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_idx   <= n_idx;
        r_q0    <= n_q0;
        r_addr  <= n_addr;
        r_bit   <= n_bit;
        r_sweep <= n_sweep;
        r_res   <= n_res;
        r_hit   <= n_hit;
        r_full  <= n_full;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_index = r_res;
    assign o_res.hit          = r_hit;
    assign o_res.full_res     = r_full;

endmodule
